FILE: rtl/core/fpmg_pkg.sv
// Fill pattern mask generator: shared types, codes, mask library and rotate helper.
// No dependencies; fpmg_pattern and the top level take names from here by scope.
`default_nettype none

package fpmg_pkg;

	// operation codes
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_FILL  = 2'd2;

	localparam int unsigned ROW_W   = 16;
	localparam int unsigned ROWS    = 16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_LOAD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} pat_ctrl_t;

	function automatic logic [ROW_W-1:0] mask_lib(input logic [3:0] sel);
		logic [ROW_W-1:0] m;
		case (sel)
			4'd0:    m = 16'h0000;
			4'd1:    m = 16'h8000;
			4'd2:    m = 16'h8080;
			4'd3:    m = 16'h8410;
			4'd4:    m = 16'h8888;
			4'd5:    m = 16'h9124;
			4'd6:    m = 16'h9494;
			4'd7:    m = 16'hA552;
			4'd8:    m = 16'hAAAA;
			4'd9:    m = 16'hEB6E;
			4'd10:   m = 16'hDDDD;
			4'd11:   m = 16'hF7F7;
			4'd12:   m = 16'hFFFF;
			4'd13:   m = 16'hE3E3;
			4'd14:   m = 16'hFF00;
			default: m = 16'h00FF;
		endcase
		return m;
	endfunction

	// right by one if rr, then left by one if ll
	function automatic logic [ROW_W-1:0] rot_step(input logic [ROW_W-1:0] v,
			input logic rr, input logic ll);
		logic [ROW_W-1:0] t;
		t = rr ? {v[0], v[ROW_W-1:1]} : v;
		t = ll ? {t[ROW_W-2:0], t[ROW_W-1]} : t;
		return t;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/fpmg_if.sv
// Valid/ready channel interfaces for command beats and result beats.
// Depends on nothing; field widths follow the block's item format.
`default_nettype none

interface fpmg_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] color_index;
	logic [7:0] write_red;
	logic [7:0] write_green;
	logic [7:0] write_blue;

	modport source(output valid, operation, color_index, write_red, write_green,
		write_blue, input ready);
	modport sink(input valid, operation, color_index, write_red, write_green,
		write_blue, output ready);
endinterface

interface fpmg_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] mask_row;
	logic [3:0]  row_number;
	logic [7:0]  read_red;
	logic [7:0]  read_green;
	logic [7:0]  read_blue;
	logic        last_row;

	modport source(output valid, mask_row, row_number, read_red, read_green,
		read_blue, last_row, input ready);
	modport sink(input valid, mask_row, row_number, read_red, read_green,
		read_blue, last_row, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/fpmg_pattern.sv
// Fill pattern row engine: two rotate steps, one per mask copy, advance the two copies per row.
// Depends on fpmg_pkg.
`default_nettype none

module fpmg_pattern (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire fpmg_pkg::pat_ctrl_t      ctrl,
	input  wire logic [7:0]               ent_red,
	input  wire logic [7:0]               ent_green,
	input  wire logic [7:0]               ent_blue,
	output logic [fpmg_pkg::ROW_W-1:0]    row,
	output logic [3:0]                    row_num,
	output logic                          last
);

	logic [fpmg_pkg::ROW_W-1:0] amask_q, bmask_q, x_q, y_q;
	logic [3:0]                 sha_q, shb_q, alin_q, pos_q, row_q;
	logic [4:0]                 cycl_q;

	// setup from the table entry
	logic [3:0]                 alin_c;
	logic [4:0]                 sum_c, cycl_c;
	logic [fpmg_pkg::ROW_W-1:0] amask_c, bmask_c;

	// row step
	logic [4:0]                 pos_inc;
	logic                       wrap;
	logic [3:0]                 pos_nxt, sh;
	logic [fpmg_pkg::ROW_W-1:0] x_nxt, y_nxt, start_mask;

	always_comb begin
		alin_c  = (ent_green == 8'd0) ? 4'd1 : ent_green[3:0];
		sum_c   = 5'(alin_c) + 5'(ent_green[7:4]);
		cycl_c  = (sum_c > 5'd16) ? 5'd16 : sum_c;
		amask_c = fpmg_pkg::mask_lib(ent_red[3:0]);
		bmask_c = fpmg_pkg::mask_lib(ent_red[7:4]);
	end

	always_comb begin
		pos_inc    = 5'(pos_q) + 5'd1;
		wrap       = (pos_inc == cycl_q);
		pos_nxt    = wrap ? 4'd0 : pos_inc[3:0];
		sh         = (pos_q < alin_q) ? sha_q : shb_q;
		start_mask = (alin_q == 4'd0) ? bmask_q : amask_q;
		if (wrap) begin
			x_nxt = start_mask;
			y_nxt = start_mask;
		end else if (pos_nxt == alin_q) begin
			x_nxt = bmask_q;
			y_nxt = bmask_q;
		end else begin
			x_nxt = fpmg_pkg::rot_step(x_q, sh[0], sh[1]);
			y_nxt = fpmg_pkg::rot_step(y_q, sh[2], sh[3]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			row_q <= '0;
		end else if (ctrl.load) begin
			pos_q <= '0;
			row_q <= '0;
		end else if (ctrl.step) begin
			pos_q <= pos_nxt;
			row_q <= row_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			amask_q <= amask_c;
			bmask_q <= bmask_c;
			sha_q   <= ent_blue[3:0];
			shb_q   <= ent_blue[7:4];
			alin_q  <= alin_c;
			cycl_q  <= cycl_c;
			x_q     <= (alin_c == 4'd0) ? bmask_c : amask_c;
			y_q     <= (alin_c == 4'd0) ? bmask_c : amask_c;
		end else if (ctrl.step) begin
			x_q <= x_nxt;
			y_q <= y_nxt;
		end
	end

	assign row     = x_q | y_q;
	assign row_num = row_q;
	assign last    = (row_q == 4'(fpmg_pkg::ROWS - 1));

endmodule

`default_nettype wire

FILE: rtl/core/fill_pattern_mask_generator_top.sv
// Fill pattern mask generator top level: colour table memory, sequencer, result register.
// Depends on fpmg_pkg, fpmg_if (fpmg_cmd_if, fpmg_res_if) and fpmg_pattern.
//
// The block holds a TABLE_DEPTH-entry red/green/blue table (reset contents: red = i,
// green = 255 - i, blue = i) and takes one command beat at a time; cmd.ready is low
// while a command is in work. A write stores the entry once the index is reduced and
// returns no beat. A read returns one beat carrying the entry, with mask_row and
// row_number zero and last_row set. A fill returns 16 beats, rows 0..15, one per cycle
// while res.ready stays high, last_row on row 15. color_index is reduced modulo
// TABLE_DEPTH by repeated subtraction, one step per cycle (color_index / TABLE_DEPTH
// steps; none when TABLE_DEPTH is 256). Operation code 3 is accepted and dropped. The
// table is a single-port memory with registered read; per-entry valid bits, cleared by
// reset, make never-written entries read as their reset contents, so there is no
// clearing pass after reset. The result register lets the next command be accepted
// while the final beat of the previous one waits.
`default_nettype none

module fill_pattern_mask_generator_top #(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	fpmg_cmd_if.sink   cmd,
	fpmg_res_if.source res
);

	localparam int unsigned AW      = $clog2(TABLE_DEPTH);
	localparam logic [8:0]  DEPTH_W = 9'(TABLE_DEPTH);

	fpmg_pkg::state_t    state_q, state_nxt;
	fpmg_pkg::pat_ctrl_t pat_ctrl;

	// captured command
	logic [1:0]  op_q;
	logic [7:0]  idx_q;
	logic [23:0] wdata_q;

	logic        cmd_acc;
	logic        idx_big;
	logic [7:0]  idx_sub;
	logic [AW-1:0] addr;

	// table storage
	logic [23:0]            mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] vld_q;
	logic [23:0]            rd_q;
	logic                   rd_vld_q;
	logic [23:0]            entry;

	// sequencer outputs
	logic mem_we, mem_re, idx_dec, out_read, out_row;

	// result register
	logic        ovalid_q;
	logic [15:0] omask_q;
	logic [3:0]  orow_q;
	logic [7:0]  ored_q, ogreen_q, oblue_q;
	logic        olast_q;
	logic        out_free;

	logic [15:0] pat_row;
	logic [3:0]  pat_num;
	logic        pat_last;

	assign cmd_acc  = cmd.valid && cmd.ready;
	// only used while idx_q >= TABLE_DEPTH, so the depth fits in 8 bits there
	assign idx_sub  = idx_q - DEPTH_W[7:0];
	assign idx_big  = ({1'b0, idx_q} >= DEPTH_W);
	assign addr     = idx_q[AW-1:0];
	assign out_free = !ovalid_q || res.ready;

	// never-written entries read as their reset contents
	assign entry = rd_vld_q ? rd_q
		: {8'(addr), 8'(8'd255 - 8'(addr)), 8'(addr)};

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			fpmg_pkg::ST_IDLE: begin
				if (cmd.valid && (cmd.operation == fpmg_pkg::OP_WRITE
						|| cmd.operation == fpmg_pkg::OP_READ
						|| cmd.operation == fpmg_pkg::OP_FILL))
					state_nxt = fpmg_pkg::ST_REDUCE;
			end
			fpmg_pkg::ST_REDUCE: begin
				if (!idx_big)
					state_nxt = (op_q == fpmg_pkg::OP_WRITE) ? fpmg_pkg::ST_IDLE
						: fpmg_pkg::ST_LOAD;
			end
			fpmg_pkg::ST_LOAD: begin
				if (op_q == fpmg_pkg::OP_FILL)
					state_nxt = fpmg_pkg::ST_EMIT;
				else if (out_free)
					state_nxt = fpmg_pkg::ST_IDLE;
			end
			fpmg_pkg::ST_EMIT: begin
				if (out_free && pat_last)
					state_nxt = fpmg_pkg::ST_IDLE;
			end
			default: state_nxt = fpmg_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd.ready     = 1'b0;
		mem_we        = 1'b0;
		mem_re        = 1'b0;
		idx_dec       = 1'b0;
		out_read      = 1'b0;
		out_row       = 1'b0;
		pat_ctrl.load = 1'b0;
		pat_ctrl.step = 1'b0;
		case (state_q)
			fpmg_pkg::ST_IDLE: cmd.ready = 1'b1;
			fpmg_pkg::ST_REDUCE: begin
				if (idx_big)
					idx_dec = 1'b1;
				else if (op_q == fpmg_pkg::OP_WRITE)
					mem_we = 1'b1;
				else
					mem_re = 1'b1;
			end
			fpmg_pkg::ST_LOAD: begin
				if (op_q == fpmg_pkg::OP_FILL)
					pat_ctrl.load = 1'b1;
				else
					out_read = out_free;
			end
			fpmg_pkg::ST_EMIT: begin
				out_row       = out_free;
				pat_ctrl.step = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= fpmg_pkg::ST_IDLE;
		else
			state_q <= state_nxt;
	end

	// command capture and index reduction
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			op_q    <= cmd.operation;
			idx_q   <= cmd.color_index;
			wdata_q <= {cmd.write_red, cmd.write_green, cmd.write_blue};
		end else if (idx_dec) begin
			idx_q <= idx_sub;
		end
	end

	// table memory: one port, registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[addr] <= wdata_q;
		if (mem_re)
			rd_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (mem_we)
				vld_q[addr] <= 1'b1;
			if (mem_re)
				rd_vld_q <= vld_q[addr];
		end
	end

	fpmg_pattern u_pattern (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (pat_ctrl),
		.ent_red   (entry[23:16]),
		.ent_green (entry[15:8]),
		.ent_blue  (entry[7:0]),
		.row       (pat_row),
		.row_num   (pat_num),
		.last      (pat_last)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ovalid_q <= 1'b0;
		else if (out_read || out_row)
			ovalid_q <= 1'b1;
		else if (res.ready)
			ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_read) begin
			omask_q  <= '0;
			orow_q   <= '0;
			ored_q   <= entry[23:16];
			ogreen_q <= entry[15:8];
			oblue_q  <= entry[7:0];
			olast_q  <= 1'b1;
		end else if (out_row) begin
			omask_q  <= pat_row;
			orow_q   <= pat_num;
			ored_q   <= '0;
			ogreen_q <= '0;
			oblue_q  <= '0;
			olast_q  <= pat_last;
		end
	end

	assign res.valid      = ovalid_q;
	assign res.mask_row   = omask_q;
	assign res.row_number = orow_q;
	assign res.read_red   = ored_q;
	assign res.read_green = ogreen_q;
	assign res.read_blue  = oblue_q;
	assign res.last_row   = olast_q;

endmodule

`default_nettype wire

FILE: test/fpmg_checker.sv
// Result checker for the fill pattern mask generator: shadows the colour table, predicts
// every result beat from the accepted command beats and compares them field by field.
// Depends on fpmg_pkg (operation codes) and fpmg_if (fpmg_cmd_if, fpmg_res_if).
module fpmg_checker #(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	fpmg_cmd_if  cmd,
	fpmg_res_if  res,
	output int   errors,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import fpmg_pkg::*;

	typedef struct packed {
		logic [15:0] mask_row;
		logic [3:0]  row_number;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        last_row;
	} beat_t;

	localparam logic [15:0] PATTERN_LIB [16] = '{
		16'h0000, 16'h8000, 16'h8080, 16'h8410, 16'h8888, 16'h9124, 16'h9494, 16'hA552,
		16'hAAAA, 16'hEB6E, 16'hDDDD, 16'hF7F7, 16'hFFFF, 16'hE3E3, 16'hFF00, 16'h00FF
	};

	logic [7:0] shadow_red   [TABLE_DEPTH];
	logic [7:0] shadow_green [TABLE_DEPTH];
	logic [7:0] shadow_blue  [TABLE_DEPTH];
	beat_t      due_beats[$];
	int         err_cnt = 0;

	function automatic logic [15:0] ror1(input logic [15:0] v);
		return {v[0], v[15:1]};
	endfunction

	function automatic logic [15:0] rol1(input logic [15:0] v);
		return {v[14:0], v[15]};
	endfunction

	// two bands of rows, each from its own base mask and rotation nibble,
	// then the band cycle repeated to fill 16 rows
	task automatic predict_fill_rows(input logic [7:0] rv, input logic [7:0] gv,
			input logic [7:0] bv);
		logic [15:0] rows [16];
		logic [15:0] x;
		logic [15:0] y;
		logic [3:0]  sh;
		beat_t       b;
		int          alin;
		int          blin;
		int          period_rows;
		alin = gv[3:0];
		blin = gv[7:4];
		if (alin + blin == 0)
			alin = 1;
		period_rows = (alin + blin > 16) ? 16 : alin + blin;
		x = '0;
		y = '0;
		sh = '0;
		for (int r = 0; r < 16; r++) begin
			if (r >= period_rows) begin
				rows[r] = rows[r - period_rows];
			end else begin
				if (r == 0) begin
					x = PATTERN_LIB[rv[3:0]];
					y = x;
					sh = bv[3:0];
				end
				if (r == alin) begin
					x = PATTERN_LIB[rv[7:4]];
					y = x;
					sh = bv[7:4];
				end
				rows[r] = x | y;
				if (sh[0]) x = ror1(x);
				if (sh[1]) x = rol1(x);
				if (sh[2]) y = ror1(y);
				if (sh[3]) y = rol1(y);
			end
			b = '0;
			b.mask_row = rows[r];
			b.row_number = 4'(r);
			b.last_row = (r == 15);
			due_beats.push_back(b);
		end
	endtask

	task automatic check_field(input string fname, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			err_cnt++;
			$display("%0t: %s mismatch, expected %h actual %h", $realtime, fname, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		beat_t       want;
		int unsigned idx;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				shadow_red[i] = 8'(i);
				shadow_green[i] = 8'(255 - i);
				shadow_blue[i] = 8'(i);
			end
			due_beats.delete();
		end else begin
			if (cmd.valid && cmd.ready) begin
				idx = cmd.color_index % TABLE_DEPTH;
				case (cmd.operation)
					OP_WRITE: begin
						shadow_red[idx] = cmd.write_red;
						shadow_green[idx] = cmd.write_green;
						shadow_blue[idx] = cmd.write_blue;
					end
					OP_READ: begin
						want = '0;
						want.red = shadow_red[idx];
						want.green = shadow_green[idx];
						want.blue = shadow_blue[idx];
						want.last_row = 1'b1;
						due_beats.push_back(want);
					end
					OP_FILL: begin
						predict_fill_rows(shadow_red[idx], shadow_green[idx], shadow_blue[idx]);
					end
					default: ; // unused code: dropped
				endcase
			end
			if (res.valid && res.ready) begin
				if (due_beats.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected result beat, mask_row %h row %0d", $realtime,
						res.mask_row, res.row_number);
				end else begin
					want = due_beats.pop_front();
					check_field("mask_row", want.mask_row, res.mask_row);
					check_field("row_number", 16'(want.row_number), 16'(res.row_number));
					check_field("read_red", 16'(want.red), 16'(res.read_red));
					check_field("read_green", 16'(want.green), 16'(res.read_green));
					check_field("read_blue", 16'(want.blue), 16'(res.read_blue));
					check_field("last_row", 16'(want.last_row), 16'(res.last_row));
				end
			end
		end
		errors <= err_cnt;
		pending <= due_beats.size();
	end

endmodule

FILE: test/tb_fill_pattern_mask_generator_top.sv
// Testbench top for fill_pattern_mask_generator_top: clock, reset, command stimulus,
// result back-pressure and verdict. Depends on fpmg_pkg, fpmg_if, the block and fpmg_checker.
module tb_fill_pattern_mask_generator_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fpmg_pkg::*;

	// code 3 has no name in the package; the block must swallow it
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 420;
	localparam int HOLD_CYCLES  = 400;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 40;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   cycle_cnt = 0;

	// idle control: calm turns idling off on both sides, hold_req asks the
	// receiver for one long stall while commands keep coming
	logic calm = 1'b0;
	logic hold_req = 1'b0;
	int   hold_left = 0;
	logic hold_done = 1'b0;

	// recently written entries, so reads and fills often see fresh data
	logic [7:0] recent_idx [8] = '{default: 8'd0};
	int         recent_ptr = 0;

	fpmg_cmd_if cmd_ch();
	fpmg_res_if res_ch();

	fill_pattern_mask_generator_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	fpmg_checker checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.res     (res_ch),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog: generous bound on the slowest legal run
	initial begin
		while (cycle_cnt < CYCLE_LIMIT)
			@(posedge clk) cycle_cnt++;
		$display("** fill_pattern_mask_generator_top: FAILED **");
		$finish;
	end

	// result side: random stalls, a calm stretch, and one long hold-off
	initial begin
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (calm) begin
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= 19);
			end
		end
	end

	// Offer one command beat; valid stays up until the beat is taken.
	// Idle gaps carry junk payload so nothing leaks from an unqualified beat.
	task automatic send_item(input logic [1:0] op, input logic [7:0] idx,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		if (!calm) begin
			while ($urandom_range(0, 99) < 19) begin
				cmd_ch.valid <= 1'b0;
				cmd_ch.operation <= 2'($urandom);
				cmd_ch.color_index <= 8'($urandom);
				cmd_ch.write_red <= 8'($urandom);
				cmd_ch.write_green <= 8'($urandom);
				cmd_ch.write_blue <= 8'($urandom);
				@(posedge clk);
			end
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.operation <= op;
		cmd_ch.color_index <= idx;
		cmd_ch.write_red <= r;
		cmd_ch.write_green <= g;
		cmd_ch.write_blue <= b;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		if (op == OP_WRITE) begin
			recent_idx[recent_ptr] = idx;
			recent_ptr = (recent_ptr + 1) % 8;
		end
	endtask

	function automatic logic [7:0] pick_index();
		if ($urandom_range(0, 1) == 0)
			return recent_idx[$urandom_range(0, 7)];
		return 8'($urandom);
	endfunction

	// green byte: mostly full range (clipped cycles), sometimes short cycles
	function automatic logic [7:0] pick_green();
		if ($urandom_range(0, 2) == 0)
			return {4'($urandom_range(0, 2)), 4'($urandom)};
		return 8'($urandom);
	endfunction

	initial begin
		int k;
		cmd_ch.valid <= 1'b0;
		cmd_ch.operation <= OP_WRITE;
		cmd_ch.color_index <= '0;
		cmd_ch.write_red <= '0;
		cmd_ch.write_green <= '0;
		cmd_ch.write_blue <= '0;
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset contents at both ends of the table
		send_item(OP_READ, 8'd0, 8'h00, 8'h00, 8'h00);
		send_item(OP_READ, 8'd255, 8'hFF, 8'hFF, 8'hFF);
		send_item(OP_FILL, 8'd0, 8'h00, 8'h00, 8'h00);     // green ff: cycle clipped
		send_item(OP_FILL, 8'd255, 8'h00, 8'h00, 8'h00);   // green 0: band A forced to 1 row
		send_item(OP_FILL, 8'd128, 8'h00, 8'h00, 8'h00);
		send_item(OP_UNUSED, 8'd255, 8'hFF, 8'hFF, 8'hFF); // must leave no trace
		// field extremes
		send_item(OP_WRITE, 8'd0, 8'h00, 8'h00, 8'h00);
		send_item(OP_READ, 8'd0, 8'h00, 8'h00, 8'h00);
		send_item(OP_FILL, 8'd0, 8'h00, 8'h00, 8'h00);
		send_item(OP_WRITE, 8'd255, 8'hFF, 8'hFF, 8'hFF);
		send_item(OP_READ, 8'd255, 8'h00, 8'h00, 8'h00);
		send_item(OP_FILL, 8'd255, 8'h00, 8'h00, 8'h00);   // right then left cancel
		// band shapes and rotations
		send_item(OP_WRITE, 8'd17, 8'h97, 8'h35, 8'h21);
		send_item(OP_FILL, 8'd17, 8'h00, 8'h00, 8'h00);
		send_item(OP_WRITE, 8'd34, 8'hD9, 8'h88, 8'h84);   // cycle exactly 16
		send_item(OP_FILL, 8'd34, 8'h00, 8'h00, 8'h00);
		send_item(OP_WRITE, 8'd51, 8'h5A, 8'h01, 8'h12);   // one-row cycle
		send_item(OP_FILL, 8'd51, 8'h00, 8'h00, 8'h00);
		send_item(OP_WRITE, 8'd68, 8'hE3, 8'h10, 8'h48);   // band A empty
		send_item(OP_FILL, 8'd68, 8'h00, 8'h00, 8'h00);
		send_item(OP_WRITE, 8'd85, 8'h3C, 8'hF2, 8'h5A);   // band B cut to 14 rows
		send_item(OP_FILL, 8'd85, 8'h00, 8'h00, 8'h00);
		send_item(OP_UNUSED, 8'd0, 8'h00, 8'h00, 8'h00);
		send_item(OP_READ, 8'd17, 8'h00, 8'h00, 8'h00);

		// random mix; one long receiver stall early, one calm stretch later
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 40)
				hold_req <= 1'b1;
			calm <= (n >= 200 && n < 280);
			k = $urandom_range(0, 99);
			if (k < 30)
				send_item(OP_WRITE, 8'($urandom), 8'($urandom), pick_green(), 8'($urandom));
			else if (k < 50)
				send_item(OP_READ, pick_index(), 8'($urandom), 8'($urandom), 8'($urandom));
			else if (k < 95)
				send_item(OP_FILL, pick_index(), 8'($urandom), 8'($urandom), 8'($urandom));
			else
				send_item(OP_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		end
		cmd_ch.valid <= 1'b0;

		// drain, then allow the block to settle
		do
			@(posedge clk);
		while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && pending == 0)
			$display("** fill_pattern_mask_generator_top: PASSED **");
		else
			$display("** fill_pattern_mask_generator_top: FAILED **");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/fpmg_pkg.sv
rtl/core/fpmg_if.sv
rtl/core/fpmg_pattern.sv
rtl/core/fill_pattern_mask_generator_top.sv
test/fpmg_checker.sv
test/tb_fill_pattern_mask_generator_top.sv
